@@ rtl/iss_pkg.sv @@
// ============================================================================
// Indexed sequence store package
// Request and response types, kind and status codes, sequencer states.
// ============================================================================
package iss_pkg;

    localparam logic [2:0] KIND_READ   = 3'd0;
    localparam logic [2:0] KIND_WRITE  = 3'd1;
    localparam logic [2:0] KIND_INSERT = 3'd2;
    localparam logic [2:0] KIND_REMOVE = 3'd3;
    localparam logic [2:0] KIND_APPEND = 3'd4;
    localparam logic [2:0] KIND_TRIM   = 3'd5;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]          kind;
        logic [4:0]          position;
        logic signed [31:0]  data_in;
    } req_t;

    typedef struct packed {
        logic signed [31:0]  data_out;
        logic [4:0]          length_now;
        logic [1:0]          status;
    } rsp_t;

    typedef struct packed {
        logic valid;
        rsp_t rsp;
    } done_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_DECIDE,
        SEQ_RD_WAIT,
        SEQ_SH_READ,
        SEQ_SH_WRITE,
        SEQ_FINISH
    } seq_state_t;

endpackage

@@ rtl/iss_ram.sv @@
// ============================================================================
// Indexed sequence store RAM
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module iss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/iss_ctrl.sv @@
// ============================================================================
// Indexed sequence store sequencer
// Checks each request, then for insert and remove moves entries one at a time
// through the RAM using a single shared step and compare unit.
// ============================================================================
module iss_ctrl #(
    parameter int DEPTH         = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  iss_pkg::req_t  req,
    output iss_pkg::done_t done,
    input  logic           take
);

    localparam int IW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PCW = (CW > 5) ? CW : 5;

    iss_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       cursor_reg, cursor_next;
    iss_pkg::req_t       req_reg, req_next;
    logic [1:0]          status_reg, status_next;
    logic [31:0]         data_out_reg, data_out_next;

    logic                     we;
    logic [IW-1:0]            waddr;
    logic [ELEMENT_WIDTH-1:0] wdata;
    logic [IW-1:0]            raddr;
    logic [ELEMENT_WIDTH-1:0] rdata;

    logic [PCW-1:0] cnt_ext;
    logic [PCW-1:0] pos_ext;
    logic [PCW-1:0] cur_ext;
    logic [PCW-1:0] step_ext;
    logic           is_insert;
    logic           more;
    logic           empty;
    logic           full;
    logic [63:0]    val_ext;
    logic [63:0]    rd_ext;
    logic [ELEMENT_WIDTH-1:0] val;

    iss_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        cnt_ext = '0;
        cnt_ext[CW-1:0] = count_reg;
        pos_ext = '0;
        pos_ext[4:0] = req_reg.position;
        cur_ext = '0;
        cur_ext[CW-1:0] = cursor_reg;
        empty = (count_reg == '0);
        full = (cnt_ext >= PCW'(DEPTH));
        is_insert = (req_reg.kind == iss_pkg::KIND_INSERT);
        step_ext = is_insert ? (cur_ext - PCW'(1)) : (cur_ext + PCW'(1));
        more = is_insert ? (cur_ext > pos_ext) : (step_ext < cnt_ext);
        val_ext = {{32{req_reg.data_in[31]}}, req_reg.data_in};
        val = val_ext[ELEMENT_WIDTH-1:0];
        rd_ext = '0;
        rd_ext[ELEMENT_WIDTH-1:0] = rdata;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        req_next      = req_reg;
        status_next   = status_reg;
        data_out_next = data_out_reg;
        req_ready     = 1'b0;
        we            = 1'b0;
        waddr         = pos_ext[IW-1:0];
        wdata         = val;
        raddr         = pos_ext[IW-1:0];
        done.valid    = 1'b0;
        done.rsp.data_out   = data_out_reg;
        done.rsp.length_now = cnt_ext[4:0];
        done.rsp.status     = status_reg;

        unique case (state_reg)
            iss_pkg::SEQ_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = iss_pkg::SEQ_DECIDE;
                end
            end
            iss_pkg::SEQ_DECIDE:
            begin
                status_next   = iss_pkg::STATUS_OK;
                data_out_next = '0;
                state_next    = iss_pkg::SEQ_FINISH;
                unique case (req_reg.kind)
                    iss_pkg::KIND_READ, iss_pkg::KIND_WRITE:
                    begin
                        if (empty)
                        begin
                            status_next = iss_pkg::STATUS_EMPTY;
                        end
                        else if (pos_ext >= cnt_ext)
                        begin
                            status_next = iss_pkg::STATUS_RANGE;
                        end
                        else if (req_reg.kind == iss_pkg::KIND_READ)
                        begin
                            state_next = iss_pkg::SEQ_RD_WAIT;
                        end
                        else
                        begin
                            we = 1'b1;
                        end
                    end
                    iss_pkg::KIND_INSERT:
                    begin
                        if (pos_ext > cnt_ext)
                        begin
                            status_next = iss_pkg::STATUS_RANGE;
                        end
                        else if (full)
                        begin
                            status_next = iss_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            cursor_next = count_reg;
                            state_next  = iss_pkg::SEQ_SH_READ;
                        end
                    end
                    iss_pkg::KIND_REMOVE:
                    begin
                        if (empty)
                        begin
                            status_next = iss_pkg::STATUS_EMPTY;
                        end
                        else if (pos_ext >= cnt_ext)
                        begin
                            status_next = iss_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            cursor_next = pos_ext[CW-1:0];
                            state_next  = iss_pkg::SEQ_SH_READ;
                        end
                    end
                    iss_pkg::KIND_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = iss_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            we         = 1'b1;
                            waddr      = cnt_ext[IW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                    iss_pkg::KIND_TRIM:
                    begin
                        if (empty)
                        begin
                            status_next = iss_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    default:
                    begin
                        status_next = iss_pkg::STATUS_OK;
                    end
                endcase
            end
            iss_pkg::SEQ_RD_WAIT:
            begin
                data_out_next = rd_ext[31:0];
                state_next    = iss_pkg::SEQ_FINISH;
            end
            iss_pkg::SEQ_SH_READ:
            begin
                if (more)
                begin
                    raddr      = step_ext[IW-1:0];
                    state_next = iss_pkg::SEQ_SH_WRITE;
                end
                else if (is_insert)
                begin
                    we         = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = iss_pkg::SEQ_FINISH;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = iss_pkg::SEQ_FINISH;
                end
            end
            iss_pkg::SEQ_SH_WRITE:
            begin
                we          = 1'b1;
                waddr       = cur_ext[IW-1:0];
                wdata       = rdata;
                cursor_next = step_ext[CW-1:0];
                state_next  = iss_pkg::SEQ_SH_READ;
            end
            iss_pkg::SEQ_FINISH:
            begin
                done.valid = 1'b1;
                if (take)
                begin
                    state_next = iss_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = iss_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iss_pkg::SEQ_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg   <= cursor_next;
        req_reg      <= req_next;
        status_reg   <= status_next;
        data_out_reg <= data_out_next;
    end

endmodule

@@ rtl/indexed_sequence_store_core.sv @@
// ============================================================================
// Indexed sequence store core
// Bounded ordered sequence of signed words with read, write, insert, remove,
// append and trim requests, one response per request.
// ============================================================================
// One request is handled at a time. After the accepting cycle, a read passes
// through the decide, read wait and finish states before its response is
// loaded into the response register; write, append, trim and failed requests
// go from decide to finish. A successful insert moves length - position
// entries and a successful remove length - position - 1; every moved
// entry needs one RAM read and one RAM write in the sequencer loop. A full
// response register that is not being taken holds the sequencer until it drains.
// The response register lets the next request be accepted while the last
// response is still waiting to be taken.
module indexed_sequence_store_core #(
    parameter int DEPTH         = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  iss_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output iss_pkg::rsp_t rsp
);

    iss_pkg::done_t done;
    logic           take;
    logic           rsp_valid_reg, rsp_valid_next;
    iss_pkg::rsp_t  rsp_reg, rsp_next;

    iss_ctrl #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .done      (done),
        .take      (take)
    );

    always_comb
    begin
        take           = done.valid && (!rsp_valid_reg || rsp_ready);
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (take)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = done.rsp;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
